// ===== src/qau_pkg.sv =====
`default_nettype none

package qau_pkg;

   // Defaults for the top-level parameters.
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COMP_WIDTH_DEF = 32;

   // Fixed widths of the item fields.
   localparam int FIELD_W = 32;
   localparam int OP_W    = 4;
   localparam int ST_W    = 2;

   // The square root works on a 64-bit radicand and yields a 32-bit root.
   localparam int SQRT_W      = 64;
   localparam int SQRT_STAGES = SQRT_W / 2;
   localparam int LEN_W       = SQRT_W / 2;

   typedef enum logic [OP_W-1:0] {
      OP_MUL      = 4'd0,
      OP_ADD      = 4'd1,
      OP_SUB      = 4'd2,
      OP_NEG      = 4'd3,
      OP_CONJ     = 4'd4,
      OP_SCALE    = 4'd5,
      OP_DIV      = 4'd6,
      OP_INVERSE  = 4'd7,
      OP_NORMALIZE = 4'd8,
      OP_SANDWICH = 4'd9,
      OP_NORMSQ   = 4'd10
   } op_type;

   localparam logic [ST_W-1:0] ST_OK   = 2'd0;
   localparam logic [ST_W-1:0] ST_DIV0 = 2'd1;
   localparam logic [ST_W-1:0] ST_SAT  = 2'd2;

   // Operation and saturation flag that travel with an item.
   typedef struct packed {
      op_type op;
      logic   sat;
   } ctl_type;

   // Component width: the parameter, capped at the field width.
   function automatic int comp_w(input int cw);
      return (cw > FIELD_W) ? FIELD_W : cw;
   endfunction

endpackage

`default_nettype wire

// ===== src/qau_sqrt.sv =====
`default_nettype none

module qau_sqrt import qau_pkg::*; (
   input  wire logic              clock,
   input  wire logic [SQRT_W-1:0] value_i,
   output logic      [LEN_W-1:0]  root_o
);

   // One result bit per stage, classic digit-by-digit integer square root.
   logic [SQRT_W-1:0] v_ff [SQRT_STAGES];
   logic [SQRT_W-1:0] r_ff [SQRT_STAGES];

   genvar g;
   for (g = 0; g < SQRT_STAGES; g++) begin : g_step
      localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2 * g);
      logic [SQRT_W-1:0] v_prev;
      logic [SQRT_W-1:0] r_prev;
      logic [SQRT_W-1:0] trial;

      if (g == 0) begin : g_first
         assign v_prev = value_i;
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[g-1];
         assign r_prev = r_ff[g-1];
      end

      assign trial = r_prev + BIT;

      always_ff @(posedge clock) begin
         if (v_prev >= trial) begin
            v_ff[g] <= v_prev - trial;
            r_ff[g] <= (r_prev >> 1) + BIT;
         end else begin
            v_ff[g] <= v_prev;
            r_ff[g] <= r_prev >> 1;
         end
      end
   end

   assign root_o = r_ff[SQRT_STAGES-1][LEN_W-1:0];

endmodule

`default_nettype wire

// ===== src/qau_div.sv =====
`default_nettype none

module qau_div import qau_pkg::*; #(
   parameter int NW = 48,
   parameter int DW = 49,
   parameter int CW = 32
) (
   input  wire logic          clock,
   input  wire logic [NW-1:0] num_i,
   input  wire logic [DW-1:0] den_i,
   input  wire logic          neg_i,
   output logic      [CW-1:0] quo_o,
   output logic               ovf_o
);

   // Restoring division of magnitudes, one quotient bit per stage. The
   // dividend shifts out at the top while quotient bits shift in below.
   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] num_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic          neg_ff [NW];

   genvar g;
   for (g = 0; g < NW; g++) begin : g_step
      logic [DW-1:0] rem_prev;
      logic [NW-1:0] num_prev;
      logic [DW-1:0] den_prev;
      logic          neg_prev;
      logic [DW:0]   trial;
      logic          ge;

      if (g == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = num_i;
         assign den_prev = den_i;
         assign neg_prev = neg_i;
      end else begin : g_next
         assign rem_prev = rem_ff[g-1];
         assign num_prev = num_ff[g-1];
         assign den_prev = den_ff[g-1];
         assign neg_prev = neg_ff[g-1];
      end

      assign trial = {rem_prev, num_prev[NW-1]};
      assign ge    = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         rem_ff[g] <= ge ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
         num_ff[g] <= {num_prev[NW-2:0], ge};
         den_ff[g] <= den_prev;
         neg_ff[g] <= neg_prev;
      end
   end

   localparam logic [NW-1:0] PMAX = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic [NW-1:0] NMAX = PMAX + NW'(1);

   logic [NW-1:0] qm;
   logic [CW-1:0] quo_in;
   logic          ovf_in;
   logic [CW-1:0] quo_ff;
   logic          ovf_ff;

   assign qm = num_ff[NW-1];

   // Apply the sign and clip to the component range.
   always_comb begin
      if (!neg_ff[NW-1]) begin
         ovf_in = qm > PMAX;
         quo_in = ovf_in ? PMAX[CW-1:0] : qm[CW-1:0];
      end else begin
         ovf_in = qm > NMAX;
         quo_in = ovf_in ? NMAX[CW-1:0] : CW'(~qm + NW'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign quo_o = quo_ff;
   assign ovf_o = ovf_ff;

endmodule

`default_nettype wire

// ===== src/qau_front.sv =====
`default_nettype none

module qau_front import qau_pkg::*; #(
   parameter int CW  = 32,
   parameter int F   = 16,
   parameter int NNW = 49
) (
   input  wire logic                clock,
   input  wire op_type              op_i,
   input  wire logic [3:0][CW-1:0]  a_i,
   input  wire logic [3:0][CW-1:0]  b_i,
   input  wire logic [CW-1:0]       s_i,
   output ctl_type                  ctl_o,
   output logic      [3:0][CW-1:0]  res_o,
   output logic      [NNW-1:0]      n_o,
   output logic      [3:0][CW-1:0]  a_o,
   output logic      [CW-1:0]       s_o
);

   localparam int PW = 2 * CW;
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] SMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   // Product of two components, floor-shifted by the fraction bits.
   function automatic logic [PW-1:0] qmul(input logic signed [CW-1:0] x,
                                          input logic signed [CW-1:0] y);
      logic signed [PW-1:0] p;
      p = PW'(x) * PW'(y);
      return p >>> F;
   endfunction

   function automatic logic ovf(input logic signed [SW-1:0] v);
      return (v > SMAX) || (v < SMIN);
   endfunction

   function automatic logic [CW-1:0] clip(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] c;
      c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
      return c[CW-1:0];
   endfunction

   function automatic logic signed [SW-1:0] ext(input logic [PW-1:0] p);
      return SW'($signed(p));
   endfunction

   // One row of the Hamilton product from the sixteen partial products.
   function automatic logic signed [SW-1:0] ham_row(input int k,
                                                    input logic [3:0][3:0][PW-1:0] p);
      logic signed [SW-1:0] r;
      case (k)
         0:       r = ext(p[3][0]) + ext(p[0][3]) + ext(p[1][2]) - ext(p[2][1]);
         1:       r = ext(p[3][1]) + ext(p[1][3]) + ext(p[2][0]) - ext(p[0][2]);
         2:       r = ext(p[3][2]) + ext(p[2][3]) + ext(p[0][1]) - ext(p[1][0]);
         default: r = ext(p[3][3]) - ext(p[0][0]) - ext(p[1][1]) - ext(p[2][2]);
      endcase
      return r;
   endfunction

   // Stage 1: all first-level products and the add-class operations.
   logic [3:0][3:0][PW-1:0] pab_ff;
   logic [3:0][PW-1:0]      sq_ff;
   logic [3:0][PW-1:0]      sc_ff;
   logic [3:0][CW-1:0]      r1_in, r1_ff;
   logic                    f1_in, f1_ff;
   logic [3:0][CW-1:0]      a1_ff;
   logic [CW-1:0]           s1_ff;
   op_type                  op1_ff;

   always_comb begin
      logic signed [SW-1:0] ak;
      logic signed [SW-1:0] bk;
      logic signed [SW-1:0] v;
      r1_in = '0;
      f1_in = 1'b0;
      for (int k = 0; k < 4; k++) begin
         ak = SW'($signed(a_i[k]));
         bk = SW'($signed(b_i[k]));
         case (op_i)
            OP_ADD:  v = ak + bk;
            OP_SUB:  v = ak - bk;
            OP_NEG:  v = -ak;
            OP_CONJ: v = (k == 3) ? ak : -ak;
            default: v = '0;
         endcase
         r1_in[k] = clip(v);
         f1_in    = f1_in | ovf(v);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pab_ff[i][j] <= qmul($signed(a_i[i]), $signed(b_i[j]));
         end
         sq_ff[i] <= qmul($signed(a_i[i]), $signed(a_i[i]));
         sc_ff[i] <= qmul($signed(a_i[i]), $signed(s_i));
      end
      r1_ff  <= r1_in;
      f1_ff  <= f1_in;
      a1_ff  <= a_i;
      s1_ff  <= s_i;
      op1_ff <= op_i;
   end

   // Stage 2: product sums, squared norm and the early result.
   logic [3:0][CW-1:0] t_in, t2_ff;
   logic               tf_in, tf2_ff;
   logic [3:0][CW-1:0] r2_in, r2_ff;
   logic               f2_in, f2_ff;
   logic signed [SW-1:0] nsum;
   logic [NNW-1:0]     n2_ff;
   logic [3:0][CW-1:0] a2_ff;
   logic [CW-1:0]      s2_ff;
   op_type             op2_ff;

   always_comb begin
      logic signed [SW-1:0] h;
      logic               sf;
      logic [3:0][CW-1:0] sres;
      tf_in = 1'b0;
      sf    = 1'b0;
      for (int k = 0; k < 4; k++) begin
         h       = ham_row(k, pab_ff);
         t_in[k] = clip(h);
         tf_in   = tf_in | ovf(h);
         sres[k] = clip(ext(sc_ff[k]));
         sf      = sf | ovf(ext(sc_ff[k]));
      end
      nsum = ext(sq_ff[0]) + ext(sq_ff[1]) + ext(sq_ff[2]) + ext(sq_ff[3]);
      r2_in = '0;
      f2_in = 1'b0;
      case (op1_ff)
         OP_MUL: begin
            r2_in = t_in;
            f2_in = tf_in;
         end
         OP_ADD, OP_SUB, OP_NEG, OP_CONJ: begin
            r2_in = r1_ff;
            f2_in = f1_ff;
         end
         OP_SCALE: begin
            r2_in = sres;
            f2_in = sf;
         end
         OP_NORMSQ: begin
            r2_in[3] = clip(nsum);
            f2_in    = ovf(nsum);
         end
         default: begin
            r2_in = '0;
            f2_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      t2_ff  <= t_in;
      tf2_ff <= tf_in;
      r2_ff  <= r2_in;
      f2_ff  <= f2_in;
      n2_ff  <= nsum[NNW-1:0];
      a2_ff  <= a1_ff;
      s2_ff  <= s1_ff;
      op2_ff <= op1_ff;
   end

   // Stage 3: second Hamilton product of the sandwich, t * conj(a).
   logic [3:0][CW-1:0]      c_in;
   logic                    cf_in;
   logic [3:0][3:0][PW-1:0] ptc_ff;
   logic [3:0][CW-1:0]      r3_ff;
   logic                    f3_ff;
   logic                    sf3_ff;
   logic [NNW-1:0]          n3_ff;
   logic [3:0][CW-1:0]      a3_ff;
   logic [CW-1:0]           s3_ff;
   op_type                  op3_ff;

   always_comb begin
      logic signed [SW-1:0] na;
      cf_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         na      = -SW'($signed(a2_ff[k]));
         c_in[k] = clip(na);
         cf_in   = cf_in | ovf(na);
      end
      c_in[3] = a2_ff[3];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            ptc_ff[i][j] <= qmul($signed(t2_ff[i]), $signed(c_in[j]));
         end
      end
      r3_ff  <= r2_ff;
      f3_ff  <= f2_ff;
      sf3_ff <= tf2_ff | cf_in;
      n3_ff  <= n2_ff;
      a3_ff  <= a2_ff;
      s3_ff  <= s2_ff;
      op3_ff <= op2_ff;
   end

   // Stage 4: finish the sandwich and merge.
   logic [3:0][CW-1:0] r4_in, r4_ff;
   logic               f4_in;
   ctl_type            ctl4_ff;
   logic [NNW-1:0]     n4_ff;
   logic [3:0][CW-1:0] a4_ff;
   logic [CW-1:0]      s4_ff;

   always_comb begin
      logic signed [SW-1:0] h;
      logic               hf;
      logic [3:0][CW-1:0] hr;
      hf = 1'b0;
      for (int k = 0; k < 4; k++) begin
         h     = ham_row(k, ptc_ff);
         hr[k] = clip(h);
         hf    = hf | ovf(h);
      end
      if (op3_ff == OP_SANDWICH) begin
         r4_in = hr;
         f4_in = sf3_ff | hf;
      end else begin
         r4_in = r3_ff;
         f4_in = f3_ff;
      end
   end

   always_ff @(posedge clock) begin
      r4_ff       <= r4_in;
      ctl4_ff.op  <= op3_ff;
      ctl4_ff.sat <= f4_in;
      n4_ff       <= n3_ff;
      a4_ff       <= a3_ff;
      s4_ff       <= s3_ff;
   end

   assign ctl_o = ctl4_ff;
   assign res_o = r4_ff;
   assign n_o   = n4_ff;
   assign a_o   = a4_ff;
   assign s_o   = s4_ff;

endmodule

`default_nettype wire

// ===== src/quaternion_arith_unit.sv =====
// Quaternion arithmetic unit, signed fixed point, fully pipelined.
// The path from start to rsp_valid runs through the front end, the 32-stage square root
// and the one-bit-per-stage dividers, then the merge register.
// Throughput: one item per cycle; busy is never raised and results cannot be stalled.
// Reset (synchronous, active high) clears only the valid pipeline; data registers keep going.
`default_nettype none

module quaternion_arith_unit import qau_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [OP_W-1:0]    req_op,
   input  wire logic [FIELD_W-1:0] req_a_x,
   input  wire logic [FIELD_W-1:0] req_a_y,
   input  wire logic [FIELD_W-1:0] req_a_z,
   input  wire logic [FIELD_W-1:0] req_a_w,
   input  wire logic [FIELD_W-1:0] req_b_x,
   input  wire logic [FIELD_W-1:0] req_b_y,
   input  wire logic [FIELD_W-1:0] req_b_z,
   input  wire logic [FIELD_W-1:0] req_b_w,
   input  wire logic [FIELD_W-1:0] req_scalar,
   output logic                    rsp_valid,
   output logic [FIELD_W-1:0]      rsp_r_x,
   output logic [FIELD_W-1:0]      rsp_r_y,
   output logic [FIELD_W-1:0]      rsp_r_z,
   output logic [FIELD_W-1:0]      rsp_r_w,
   output logic [ST_W-1:0]         rsp_status
);

   // Component width, squared-norm width, dividend width and divisor width.
   // The squared norm is a sum of four floor-shifted squares, so it is never
   // negative and is at most 2^(2*CW-FRAC_BITS).
   localparam int CW  = comp_w(COMP_WIDTH);
   localparam int NNW = 2 * CW - FRAC_BITS + 1;
   localparam int NW  = CW + FRAC_BITS;
   localparam int DW  = (NNW > LEN_W + 1) ? NNW : LEN_W + 1;
   localparam int LAT = 4 + SQRT_STAGES + NW + 2;

   // The unit takes an item every cycle.
   assign busy = 1'b0;

   // Each field is read as its low CW bits, taken as a signed value.
   logic [3:0][CW-1:0] a_dec;
   logic [3:0][CW-1:0] b_dec;

   assign a_dec[0] = req_a_x[CW-1:0];
   assign a_dec[1] = req_a_y[CW-1:0];
   assign a_dec[2] = req_a_z[CW-1:0];
   assign a_dec[3] = req_a_w[CW-1:0];
   assign b_dec[0] = req_b_x[CW-1:0];
   assign b_dec[1] = req_b_y[CW-1:0];
   assign b_dec[2] = req_b_z[CW-1:0];
   assign b_dec[3] = req_b_w[CW-1:0];

   // Front end: every multiply-based and add-based operation, plus the
   // squared norm that the inverse and normalize paths need.
   ctl_type            fe_ctl;
   logic [3:0][CW-1:0] fe_res;
   logic [NNW-1:0]     fe_n;
   logic [3:0][CW-1:0] fe_a;
   logic [CW-1:0]      fe_s;

   qau_front #(
      .CW  (CW),
      .F   (FRAC_BITS),
      .NNW (NNW)
   ) u_front (
      .clock (clock),
      .op_i  (op_type'(req_op)),
      .a_i   (a_dec),
      .b_i   (b_dec),
      .s_i   (req_scalar[CW-1:0]),
      .ctl_o (fe_ctl),
      .res_o (fe_res),
      .n_o   (fe_n),
      .a_o   (fe_a),
      .s_o   (fe_s)
   );

   // Radicand for normalize: the squared norm scaled up by the fraction bits,
   // pinned to all ones when it does not fit in 64 bits.
   logic [SQRT_W+FRAC_BITS-1:0] wide_full;
   logic [SQRT_W-1:0]           wide;
   logic [LEN_W-1:0]            len;

   assign wide_full = (SQRT_W + FRAC_BITS)'(fe_n) << FRAC_BITS;
   assign wide      = (|wide_full[SQRT_W+FRAC_BITS-1:SQRT_W]) ? '1
                                                               : wide_full[SQRT_W-1:0];

   qau_sqrt u_sqrt (
      .clock   (clock),
      .value_i (wide),
      .root_o  (len)
   );

   // Everything else the item needs rides alongside the square root.
   typedef struct packed {
      ctl_type            ctl;
      logic [3:0][CW-1:0] res;
      logic [NNW-1:0]     n;
      logic [3:0][CW-1:0] a;
      logic [CW-1:0]      s;
   } sq_line_type;

   sq_line_type sq_line_ff [SQRT_STAGES];

   always_ff @(posedge clock) begin
      sq_line_ff[0].ctl <= fe_ctl;
      sq_line_ff[0].res <= fe_res;
      sq_line_ff[0].n   <= fe_n;
      sq_line_ff[0].a   <= fe_a;
      sq_line_ff[0].s   <= fe_s;
      for (int k = 1; k < SQRT_STAGES; k++) begin
         sq_line_ff[k] <= sq_line_ff[k-1];
      end
   end

   sq_line_type sq_tap;
   assign sq_tap = sq_line_ff[SQRT_STAGES-1];

   // Divider operands. The divisor is shared by all four lanes; each lane
   // divides the magnitude of its own component, scaled by the fraction bits,
   // and the sign of the quotient is settled up front.
   logic [DW-1:0]      den;
   logic               dz;
   logic [3:0][NW-1:0] num;
   logic [3:0]         neg;
   logic [CW-1:0]      s_mag;

   always_comb begin
      logic          a_neg;
      logic [CW-1:0] a_mag;
      s_mag = sq_tap.s[CW-1] ? CW'(~sq_tap.s + CW'(1)) : sq_tap.s;
      case (sq_tap.ctl.op)
         OP_DIV: begin
            den = DW'(s_mag);
            dz  = (sq_tap.s == '0);
         end
         OP_INVERSE: begin
            den = DW'(sq_tap.n);
            dz  = (sq_tap.n == '0);
         end
         OP_NORMALIZE: begin
            den = DW'(len);
            dz  = (len == '0);
         end
         default: begin
            den = DW'(s_mag);
            dz  = 1'b0;
         end
      endcase
      for (int k = 0; k < 4; k++) begin
         a_neg  = sq_tap.a[k][CW-1];
         a_mag  = a_neg ? CW'(~sq_tap.a[k] + CW'(1)) : sq_tap.a[k];
         num[k] = {a_mag, {FRAC_BITS{1'b0}}};
         case (sq_tap.ctl.op)
            OP_DIV:     neg[k] = a_neg ^ sq_tap.s[CW-1];
            OP_INVERSE: neg[k] = (k == 3) ? a_neg : !a_neg;
            default:    neg[k] = a_neg;
         endcase
      end
   end

   // Four divider lanes, one per component.
   logic [3:0][CW-1:0] quo;
   logic [3:0]         quo_ovf;

   genvar g;
   for (g = 0; g < 4; g++) begin : g_lane
      qau_div #(
         .NW (NW),
         .DW (DW),
         .CW (CW)
      ) u_div (
         .clock (clock),
         .num_i (num[g]),
         .den_i (den),
         .neg_i (neg[g]),
         .quo_o (quo[g]),
         .ovf_o (quo_ovf[g])
      );
   end

   // The non-dividing result and the zero-divisor flag wait for the lanes.
   typedef struct packed {
      ctl_type            ctl;
      logic [3:0][CW-1:0] res;
      logic               dz;
   } div_line_type;

   div_line_type div_line_ff [NW+1];

   always_ff @(posedge clock) begin
      div_line_ff[0].ctl <= sq_tap.ctl;
      div_line_ff[0].res <= sq_tap.res;
      div_line_ff[0].dz  <= dz;
      for (int k = 1; k <= NW; k++) begin
         div_line_ff[k] <= div_line_ff[k-1];
      end
   end

   div_line_type div_tap;
   assign div_tap = div_line_ff[NW];

   // Merge: pick the divider lanes or the front-end result and form the
   // status. A zero divisor wins over saturation and forces a zero result.
   logic [3:0][CW-1:0] out_in,    out_ff;
   logic [ST_W-1:0]    status_in, status_ff;

   always_comb begin
      case (div_tap.ctl.op)
         OP_DIV, OP_INVERSE, OP_NORMALIZE: begin
            if (div_tap.dz) begin
               out_in    = '0;
               status_in = ST_DIV0;
            end else begin
               out_in    = quo;
               status_in = (|quo_ovf) ? ST_SAT : ST_OK;
            end
         end
         default: begin
            out_in    = div_tap.res;
            status_in = div_tap.ctl.sat ? ST_SAT : ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      out_ff    <= out_in;
      status_ff <= status_in;
   end

   // Valid pipeline: the only state that reset touches.
   logic [LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   assign rsp_valid  = vld_ff[LAT-1];
   assign rsp_r_x    = FIELD_W'($signed(out_ff[0]));
   assign rsp_r_y    = FIELD_W'($signed(out_ff[1]));
   assign rsp_r_z    = FIELD_W'($signed(out_ff[2]));
   assign rsp_r_w    = FIELD_W'($signed(out_ff[3]));
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

// ===== sim/tb_quaternion_arith_unit.sv =====
`default_nettype none

module tb_quaternion_arith_unit;
   import qau_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // PIPE_CYCLES matches the pipeline depth at the default sizes; the tail wait covers it easily.
   localparam int PIPE_CYCLES = 86;
   localparam int RANDOM_ITEMS = 790;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;
   localparam logic [31:0] ONE_Q = 32'h0001_0000;
   localparam logic [31:0] MAX_Q = 32'h7fff_ffff;
   localparam logic [31:0] MIN_Q = 32'h8000_0000;

   typedef struct packed {
      logic [31:0]     x;
      logic [31:0]     y;
      logic [31:0]     z;
      logic [31:0]     w;
      logic [ST_W-1:0] st;
   } quat_result_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [OP_W-1:0] req_op;
   logic [FIELD_W-1:0] req_a_x, req_a_y, req_a_z, req_a_w;
   logic [FIELD_W-1:0] req_b_x, req_b_y, req_b_z, req_b_w;
   logic [FIELD_W-1:0] req_scalar;
   logic rsp_valid;
   logic [FIELD_W-1:0] rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w;
   logic [ST_W-1:0] rsp_status;

   quaternion_arith_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z), .req_a_w(req_a_w),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z), .req_b_w(req_b_w),
      .req_scalar(req_scalar),
      .rsp_valid(rsp_valid),
      .rsp_r_x(rsp_r_x), .rsp_r_y(rsp_r_y), .rsp_r_z(rsp_r_z), .rsp_r_w(rsp_r_w),
      .rsp_status(rsp_status)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Results still in flight, oldest first.
   quat_result_type pending_q[$];
   int items_sent;
   int results_seen;
   int mismatches;
   bit clip_seen;

   // ---------------------------------------------------------------------
   // Fixed-point predictor. All arithmetic is done in 64 bits so that the
   // intermediate sums are exact; clipping to the 32-bit component range
   // records that saturation happened somewhere in the item.
   // ---------------------------------------------------------------------
   function automatic longint clip(input longint v);
      if (v > QMAX) begin
         clip_seen = 1'b1;
         return QMAX;
      end
      if (v < QMIN) begin
         clip_seen = 1'b1;
         return QMIN;
      end
      return v;
   endfunction

   // Product of two components, shifted down with rounding toward minus infinity.
   function automatic longint fx_mul(input longint p, input longint q);
      longint prod;
      prod = p * q;
      return prod >>> FRAC_BITS_DEF;
   endfunction

   // Quotient scaled up by the fraction bits, truncated toward zero, then clipped.
   function automatic longint fx_div(input longint num, input longint den);
      return clip((num * (64'sd1 <<< FRAC_BITS_DEF)) / den);
   endfunction

   // Component order is x, y, z, w.
   function automatic logic [255:0] hamilton_product(input logic [255:0] pv,
                                                      input logic [255:0] qv);
      longint p[4];
      longint q[4];
      longint r[4];
      for (int i = 0; i < 4; i++) begin
         p[i] = $signed(pv[i*64 +: 64]);
         q[i] = $signed(qv[i*64 +: 64]);
      end
      r[0] = clip(fx_mul(p[3], q[0]) + fx_mul(p[0], q[3]) + fx_mul(p[1], q[2])
                  - fx_mul(p[2], q[1]));
      r[1] = clip(fx_mul(p[3], q[1]) + fx_mul(p[1], q[3]) + fx_mul(p[2], q[0])
                  - fx_mul(p[0], q[2]));
      r[2] = clip(fx_mul(p[3], q[2]) + fx_mul(p[2], q[3]) + fx_mul(p[0], q[1])
                  - fx_mul(p[1], q[0]));
      r[3] = clip(fx_mul(p[3], q[3]) - fx_mul(p[0], q[0]) - fx_mul(p[1], q[1])
                  - fx_mul(p[2], q[2]));
      return {r[3], r[2], r[1], r[0]};
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic quat_result_type predict_quat(input logic [OP_W-1:0] op,
                                                    input logic [3:0][31:0] a,
                                                    input logic [3:0][31:0] b,
                                                    input logic [31:0] s);
      longint av[4];
      longint bv[4];
      longint r[4];
      longint sv;
      longint nsq;
      longint unsigned wide;
      longint len;
      logic [255:0] ap, bp, tp, cp, rp;
      logic [ST_W-1:0] st;
      quat_result_type res;
      for (int i = 0; i < 4; i++) begin
         av[i] = $signed(a[i]);
         bv[i] = $signed(b[i]);
         r[i] = 0;
      end
      sv = $signed(s);
      st = ST_OK;
      clip_seen = 1'b0;
      nsq = 0;
      for (int i = 0; i < 4; i++) nsq += fx_mul(av[i], av[i]);
      ap = {av[3], av[2], av[1], av[0]};
      bp = {bv[3], bv[2], bv[1], bv[0]};
      case (op)
         OP_MUL: begin
            rp = hamilton_product(ap, bp);
            for (int i = 0; i < 4; i++) r[i] = $signed(rp[i*64 +: 64]);
         end
         OP_ADD: for (int i = 0; i < 4; i++) r[i] = clip(av[i] + bv[i]);
         OP_SUB: for (int i = 0; i < 4; i++) r[i] = clip(av[i] - bv[i]);
         OP_NEG: for (int i = 0; i < 4; i++) r[i] = clip(-av[i]);
         OP_CONJ: begin
            for (int i = 0; i < 3; i++) r[i] = clip(-av[i]);
            r[3] = av[3];
         end
         OP_SCALE: for (int i = 0; i < 4; i++) r[i] = clip(fx_mul(av[i], sv));
         OP_DIV: begin
            if (sv == 0) st = ST_DIV0;
            else for (int i = 0; i < 4; i++) r[i] = fx_div(av[i], sv);
         end
         OP_INVERSE: begin
            if (nsq == 0) begin
               st = ST_DIV0;
            end else begin
               for (int i = 0; i < 3; i++) r[i] = fx_div(-av[i], nsq);
               r[3] = fx_div(av[3], nsq);
            end
         end
         OP_NORMALIZE: begin
            // The radicand is capped at all ones when the shift would overflow.
            if (longint'(nsq) > longint'(64'hffff_ffff_ffff_ffff >> (FRAC_BITS_DEF + 1)) * 2 + 1)
               wide = 64'hffff_ffff_ffff_ffff;
            else
               wide = longint'(nsq) << FRAC_BITS_DEF;
            len = int_sqrt(wide);
            if (len == 0) st = ST_DIV0;
            else for (int i = 0; i < 4; i++) r[i] = fx_div(av[i], len);
         end
         OP_SANDWICH: begin
            tp = hamilton_product(ap, bp);
            cp = {av[3], clip(-av[2]), clip(-av[1]), clip(-av[0])};
            rp = hamilton_product(tp, cp);
            for (int i = 0; i < 4; i++) r[i] = $signed(rp[i*64 +: 64]);
         end
         OP_NORMSQ: r[3] = clip(nsq);
         default: ;
      endcase
      if (st == ST_OK && clip_seen) st = ST_SAT;
      res.x = r[0][31:0];
      res.y = r[1][31:0];
      res.z = r[2][31:0];
      res.w = r[3][31:0];
      res.st = st;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: waits a random number of idle cycles, then holds the item until
   // the unit takes it. A zero gap keeps start high straight into the next
   // item, so start is only ever given one assignment per edge.
   // ---------------------------------------------------------------------
   task automatic send_quat(input logic [OP_W-1:0] op, input logic [3:0][31:0] a,
                            input logic [3:0][31:0] b, input logic [31:0] s);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_a_x <= a[0]; req_a_y <= a[1]; req_a_z <= a[2]; req_a_w <= a[3];
      req_b_x <= b[0]; req_b_y <= b[1]; req_b_z <= b[2]; req_b_w <= b[3];
      req_scalar <= s;
      do @(posedge clock); while (busy);
      pending_q.push_back(predict_quat(op, a, b, s));
      items_sent++;
   endtask

   // Stop sending and let everything in flight come back.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   // Random component: full range, small magnitudes around unity, tiny values near zero, or an extreme.
   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2, 3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         4: return $urandom_range(0, 32'h0000_0400) - 32'h0000_0200;
         default: begin
            case ($urandom_range(0, 4))
               0: return MAX_Q;
               1: return MIN_Q;
               2: return 32'd0;
               3: return ONE_Q;
               default: return -ONE_Q;
            endcase
         end
      endcase
   endfunction

   function automatic logic [3:0][31:0] rand_quat();
      logic [3:0][31:0] q;
      for (int i = 0; i < 4; i++) q[i] = rand_comp();
      return q;
   endfunction

   // Every operation on the corners of the range, plus the divide-by-zero and
   // negate-the-minimum cases and two of the unused operation codes.
   task automatic test_directed();
      logic [3:0][31:0] ones, maxs, mins, zero, tiny;
      ones = {ONE_Q, ONE_Q, ONE_Q, ONE_Q};
      maxs = {MAX_Q, MAX_Q, MAX_Q, MAX_Q};
      mins = {MIN_Q, MIN_Q, MIN_Q, MIN_Q};
      zero = '0;
      tiny = {32'd1, 32'd1, 32'd1, 32'd1};
      for (int op = OP_MUL; op <= OP_NORMSQ; op++)
         send_quat(op[OP_W-1:0], maxs, mins, MAX_Q);
      send_quat(OP_MUL, ones, ones, ONE_Q);
      send_quat(OP_ADD, maxs, maxs, ONE_Q);
      send_quat(OP_SUB, mins, maxs, ONE_Q);
      send_quat(OP_NEG, mins, zero, ONE_Q);
      send_quat(OP_CONJ, mins, zero, ONE_Q);
      send_quat(OP_SCALE, mins, zero, MIN_Q);
      send_quat(OP_DIV, ones, zero, 32'd0);
      send_quat(OP_DIV, maxs, zero, 32'd1);
      send_quat(OP_INVERSE, zero, zero, 32'd0);
      send_quat(OP_INVERSE, tiny, zero, 32'd0);
      send_quat(OP_NORMALIZE, zero, zero, 32'd0);
      send_quat(OP_NORMALIZE, ones, zero, 32'd0);
      send_quat(OP_SANDWICH, ones, maxs, 32'd0);
      send_quat(4'd11, maxs, maxs, MAX_Q);
      send_quat(4'd15, mins, mins, MIN_Q);
   endtask

   // Mostly defined operations on mixed operands; a few unused codes in between.
   task automatic test_random(input int count);
      logic [OP_W-1:0] op;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 19) == 0) op = OP_W'($urandom_range(11, 15));
         else op = OP_W'($urandom_range(OP_MUL, OP_NORMSQ));
         send_quat(op, rand_quat(), rand_quat(),
                   $urandom_range(0, 7) == 0 ? 32'd0 : rand_comp());
      end
   endtask

   // A burst of twenty items with random gaps, a full drain, then traffic again on an empty pipeline.
   task automatic test_pause();
      for (int n = 0; n < 20; n++)
         send_quat(OP_W'($urandom_range(OP_MUL, OP_NORMSQ)), rand_quat(), rand_quat(),
                   rand_comp());
      drain_results();
      test_random(20);
   endtask

   // Every result must match the oldest prediction, field by field.
   always @(posedge clock) begin
      quat_result_type exp_r;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with nothing pending at %0t", $realtime);
         end else begin
            exp_r = pending_q.pop_front();
            if (exp_r !== {rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w, rsp_status}) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t: expected x=%h y=%h z=%h w=%h st=%0d,",
                           $realtime, exp_r.x, exp_r.y, exp_r.z, exp_r.w, exp_r.st);
                  $display("   got x=%h y=%h z=%h w=%h st=%0d",
                           rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w, rsp_status);
               end
            end
         end
      end
   end

   initial begin
      items_sent = 0;
      results_seen = 0;
      mismatches = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_op <= '0;
      {req_a_x, req_a_y, req_a_z, req_a_w} <= '0;
      {req_b_x, req_b_y, req_b_z, req_b_w} <= '0;
      req_scalar <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pause();
      test_random(RANDOM_ITEMS);
      drain_results();
      repeat (PIPE_CYCLES + 20) @(posedge clock);
      if (pending_q.size() != 0) mismatches++;
      $display("Covered %0d items over all operation codes, %0d results checked.",
               items_sent, results_seen);
      if (mismatches == 0) begin
         $display("tb_quaternion_arith_unit OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_quaternion_arith_unit NOT OK");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_quaternion_arith_unit NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

// ===== quaternion_arith_unit.f =====
src/qau_pkg.sv
src/qau_sqrt.sv
src/qau_div.sv
src/qau_front.sv
src/quaternion_arith_unit.sv
sim/tb_quaternion_arith_unit.sv
